>>> rtl/ursi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ursi_pkg: shared types and constants of the run-sketch insert block
// Entry layout, result layout, state enums and hash constants.
// ----------------------------------------------------------------------------
package ursi_pkg;

  localparam int URSI_ROWS = 4;
  localparam int URSI_COLS = 4096;

  localparam logic [31:0] URSI_SEED_BASE = 32'd1324534127;
  localparam logic [31:0] URSI_SEED_STEP = 32'd6156137;
  localparam logic [31:0] URSI_C1        = 32'hcc9e2d51;
  localparam logic [31:0] URSI_C2        = 32'h1b873593;
  localparam logic [31:0] URSI_C3        = 32'h85ebca6b;
  localparam logic [31:0] URSI_C4        = 32'hc2b2ae35;
  localparam logic [31:0] URSI_ROUND_ADD = 32'he6546b64;
  localparam logic [31:0] URSI_KEY_BYTES = 32'd13;
  localparam logic [7:0]  URSI_RUN_MAX   = 8'd255;
  localparam logic [31:0] URSI_COUNT_MAX = 32'hFFFFFFFF;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } ursi_op_e;

  typedef struct packed {
    logic [63:0] key_low;
    logic [39:0] key_high;
    logic [31:0] count;
    logic [7:0]  peak;
    logic [7:0]  run;
  } ursi_entry_t;

  typedef struct packed {
    logic [31:0] flow_estimate;
    logic [63:0] bucket_key_low;
    logic [39:0] bucket_key_high;
    logic [31:0] bucket_count;
    logic [7:0]  bucket_peak_run;
    logic [7:0]  bucket_cur_run;
  } ursi_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_MUL,
    ST_WRITE,
    ST_DONE
  } ursi_state_e;

  typedef enum logic [3:0] {
    HS_IDLE,
    HS_MIX1,
    HS_MIX2,
    HS_RND0,
    HS_RND1,
    HS_RND2,
    HS_FIN1,
    HS_FIN2,
    HS_FIN3,
    HS_MOD
  } ursi_hphase_e;

  function automatic logic [31:0] ursi_seed(input int unsigned row);
    logic [31:0] r32;
    r32 = 32'(row);
    return 32'(URSI_SEED_BASE + URSI_SEED_STEP * r32);
  endfunction

endpackage

>>> rtl/ursi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ursi_in_if: request channel
// Valid/ready channel that carries one insert or bucket-read request.
// ----------------------------------------------------------------------------
interface ursi_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] key_low;
  logic [39:0] key_high;
  logic [31:0] rand_row0;
  logic [31:0] rand_row1;
  logic [31:0] rand_row2;
  logic [31:0] rand_row3;
  logic [1:0]  read_row;
  logic [11:0] read_col;

  modport source (output valid, opcode, key_low, key_high, rand_row0, rand_row1,
                  rand_row2, rand_row3, read_row, read_col, input ready);
  modport sink (input valid, opcode, key_low, key_high, rand_row0, rand_row1,
                rand_row2, rand_row3, read_row, read_col, output ready);
endinterface

>>> rtl/ursi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ursi_out_if: result channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface ursi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] flow_estimate;
  logic [63:0] bucket_key_low;
  logic [39:0] bucket_key_high;
  logic [31:0] bucket_count;
  logic [7:0]  bucket_peak_run;
  logic [7:0]  bucket_cur_run;

  modport source (output valid, flow_estimate, bucket_key_low, bucket_key_high,
                  bucket_count, bucket_peak_run, bucket_cur_run, input ready);
  modport sink (input valid, flow_estimate, bucket_key_low, bucket_key_high,
                bucket_count, bucket_peak_run, bucket_cur_run, output ready);
endinterface

>>> rtl/unbiased_run_sketch_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unbiased_run_sketch_insert_core: heavy-hitter sketch, insert and read
// Flow sketch of ROWS rows by COLS buckets held in one RAM per row.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request: opcode 0 inserts the 13-byte key, using one
//   random word per row for the replacement test; opcode 1 reads the bucket
//   at read_row/read_col. out_o returns exactly one result per request.
//   An insert reports the largest count among rows now holding the key.
// Flow:
//   One request is in flight at a time. An insert runs the hash unit (one
//   multiply per lane per cycle, then mod COLS by reciprocal multiply), then
//   RAM read, compare, replacement multiply, write back and result load. A
//   read skips the hash, the replacement multiply and the write back. The
//   next request can be taken in the cycle after the result loads.
// Reset:
//   After rst_ni the block sweeps all rows in parallel, one column per
//   cycle, writing empty buckets with ready low.
// Stalls:
//   The result register holds while out ready is low; a finished request
//   waits for it, but a new request may be taken while the result waits.
// ----------------------------------------------------------------------------
module unbiased_run_sketch_insert_core
  import ursi_pkg::*;
#(
  parameter int ROWS = URSI_ROWS,
  parameter int COLS = URSI_COLS
) (
  input logic      clk_i,
  input logic      rst_ni,
  ursi_in_if.sink  in_i,
  ursi_out_if.source out_o
);

  localparam int CW = $clog2(COLS);

  ursi_state_e state_q, state_d;
  logic [CW-1:0] clr_q;

  // Request registers.
  logic        op_q;
  logic [63:0] klo_q;
  logic [39:0] khi_q;
  logic [3:0][31:0] rand_q;
  logic [1:0]  rrow_q;
  logic [11:0] rcol_q;

  // Bucket pipeline registers.
  ursi_entry_t [ROWS-1:0] ent_q;
  logic [ROWS-1:0] match_q;
  logic [ROWS-1:0][63:0] p1_q;
  logic [ROWS-1:0] pass_q;

  ursi_result_t res_q, res_d;
  ursi_result_t out_q;
  logic out_valid_q;

  logic accept;
  logic hash_start, hash_done;
  logic [ROWS-1:0][CW-1:0] hash_col;

  logic [ROWS-1:0] mem_we, mem_re;
  logic [ROWS-1:0][CW-1:0] mem_addr;
  ursi_entry_t [ROWS-1:0] mem_wdata, mem_rdata, new_ent;

  logic [31:0] rcol32, rrow32;
  logic [CW-1:0] rcol_addr;
  logic rd_in_range;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign hash_start = accept && (in_i.opcode == OP_INSERT);

  assign rcol32      = 32'(rcol_q);
  assign rrow32      = 32'(rrow_q);
  assign rcol_addr   = rcol32[CW-1:0];
  assign rd_in_range = (rrow32 < 32'(ROWS)) && (rcol32 < 32'(COLS));

  ursi_hash #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (hash_start),
    .key_low_i  (in_i.key_low),
    .key_high_i (in_i.key_high),
    .done_o     (hash_done),
    .col_o      (hash_col)
  );

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    ursi_row_mem #(
      .DEPTH (COLS),
      .AW    (CW)
    ) u_mem (
      .clk_i   (clk_i),
      .we_i    (mem_we[r]),
      .re_i    (mem_re[r]),
      .addr_i  (mem_addr[r]),
      .wdata_i (mem_wdata[r]),
      .rdata_o (mem_rdata[r])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CW'(COLS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.opcode == OP_READ) ? ST_READ : ST_HASH;
        end
      end
      ST_HASH:  if (hash_done) state_d = ST_READ;
      ST_READ:  state_d = ST_CMP;
      ST_CMP:   state_d = (op_q == OP_READ) ? ST_DONE : ST_MUL;
      ST_MUL:   state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // RAM control: sweep on clear, read the addressed column, write back.
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      mem_we[r]    = 1'b0;
      mem_re[r]    = 1'b0;
      mem_addr[r]  = (op_q == OP_READ) ? rcol_addr : hash_col[r];
      mem_wdata[r] = new_ent[r];
      unique case (state_q)
        ST_CLEAR: begin
          mem_we[r]    = 1'b1;
          mem_addr[r]  = clr_q;
          mem_wdata[r] = '0;
        end
        ST_READ:  mem_re[r] = 1'b1;
        ST_WRITE: mem_we[r] = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Bucket update per row, the estimate over rows and the bucket read result.
  always_comb begin
    logic [31:0] best;
    best = '0;
    for (int r = 0; r < ROWS; r++) begin
      new_ent[r] = ent_q[r];
      if (ent_q[r].count == '0) begin
        new_ent[r].key_low  = klo_q;
        new_ent[r].key_high = khi_q;
        new_ent[r].count    = 32'd1;
        new_ent[r].peak     = 8'd1;
        new_ent[r].run      = 8'd1;
      end else if (match_q[r]) begin
        if (ent_q[r].count != URSI_COUNT_MAX) begin
          new_ent[r].count = ent_q[r].count + 32'd1;
        end
        if (ent_q[r].run < URSI_RUN_MAX) begin
          new_ent[r].run = ent_q[r].run + 8'd1;
          if (ent_q[r].peak < ent_q[r].run + 8'd1) begin
            new_ent[r].peak = ent_q[r].run + 8'd1;
          end
        end
      end else begin
        new_ent[r].run = '0;
        if (pass_q[r]) begin
          new_ent[r].key_low  = klo_q;
          new_ent[r].key_high = khi_q;
          new_ent[r].peak     = 8'd1;
          new_ent[r].run      = 8'd1;
        end
      end
      if (new_ent[r].key_low == klo_q && new_ent[r].key_high == khi_q &&
          new_ent[r].count > best) begin
        best = new_ent[r].count;
      end
    end

    res_d = res_q;
    if (state_q == ST_WRITE) begin
      res_d = '0;
      res_d.flow_estimate = best;
    end else if (state_q == ST_CMP && op_q == OP_READ) begin
      res_d = '0;
      for (int r = 0; r < ROWS; r++) begin
        if (rd_in_range && rrow32 == 32'(r)) begin
          res_d.bucket_key_low  = mem_rdata[r].key_low;
          res_d.bucket_key_high = mem_rdata[r].key_high;
          res_d.bucket_count    = mem_rdata[r].count;
          res_d.bucket_peak_run = mem_rdata[r].peak;
          res_d.bucket_cur_run  = mem_rdata[r].run;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + CW'(1);
      end
      if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload, compare pipeline and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= in_i.opcode;
      klo_q     <= in_i.key_low;
      khi_q     <= in_i.key_high;
      rand_q[0] <= in_i.rand_row0;
      rand_q[1] <= in_i.rand_row1;
      rand_q[2] <= in_i.rand_row2;
      rand_q[3] <= in_i.rand_row3;
      rrow_q    <= in_i.read_row;
      rcol_q    <= in_i.read_col;
    end
    if (state_q == ST_CMP) begin
      for (int r = 0; r < ROWS; r++) begin
        ent_q[r]   <= mem_rdata[r];
        match_q[r] <= (mem_rdata[r].key_low == klo_q) && (mem_rdata[r].key_high == khi_q);
        p1_q[r]    <= 64'(rand_q[r]) * 64'(mem_rdata[r].count);
      end
    end
    // Replacement passes when rand * count * peak stays below 2^32.
    if (state_q == ST_MUL) begin
      for (int r = 0; r < ROWS; r++) begin
        pass_q[r] <= (rand_q[r] == '0) || (ent_q[r].peak == '0) ||
                     ((p1_q[r][63:32] == '0) &&
                      ((40'(p1_q[r][31:0]) * 40'(ent_q[r].peak)) >> 32) == 40'd0);
      end
    end
    res_q <= res_d;
    if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.flow_estimate   = out_q.flow_estimate;
  assign out_o.bucket_key_low  = out_q.bucket_key_low;
  assign out_o.bucket_key_high = out_q.bucket_key_high;
  assign out_o.bucket_count    = out_q.bucket_count;
  assign out_o.bucket_peak_run = out_q.bucket_peak_run;
  assign out_o.bucket_cur_run  = out_q.bucket_cur_run;

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q != ST_CLEAR)
    else $error("request taken during clear sweep");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|mem_we) |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
    else $error("RAM write outside clear or write back");

  a_hash_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HASH && hash_done) |=> state_q == ST_READ)
    else $error("hash done did not start the RAM read");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done state");

endmodule

>>> rtl/ursi_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ursi_row_mem: bucket memory of one row
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ursi_row_mem
  import ursi_pkg::*;
#(
  parameter int DEPTH = URSI_COLS,
  parameter int AW    = $clog2(URSI_COLS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  ursi_entry_t   wdata_i,
  output ursi_entry_t   rdata_o
);

  ursi_entry_t mem_q [DEPTH];
  ursi_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ursi_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ursi_hash: multi-cycle row hash and column reduction
// Seeded 13-byte MurmurHash3 for all rows in parallel lanes, one multiply
// per lane per cycle, then hash mod COLS by reciprocal multiply and fold.
// ----------------------------------------------------------------------------
module ursi_hash
  import ursi_pkg::*;
#(
  parameter int ROWS = URSI_ROWS,
  parameter int COLS = URSI_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [63:0]                     key_low_i,
  input  logic [39:0]                     key_high_i,
  output logic                            done_o,
  output logic [ROWS-1:0][$clog2(COLS)-1:0] col_o
);

  localparam int CW = $clog2(COLS);
  localparam int MOD_LAST = 2;
  localparam logic [31:0] COLS32 = 32'(COLS);
  // floor(2^(32+CW) / COLS): quotient estimate is exact or one short
  localparam logic [32:0] RECIP = 33'((65'(1) << (32 + CW)) / 65'(COLS));

  ursi_hphase_e phase_q, phase_d;
  logic [2:0] cnt_q;
  logic [3:0][31:0] kb_q;
  logic [ROWS-1:0][31:0] h_q;
  logic [ROWS-1:0][64:0] prod_q;
  logic [ROWS-1:0][31:0] qd_q;
  logic [ROWS-1:0][CW-1:0] rem_q;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] hround(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = rotl(h ^ k, 13);
    return 32'(t + (t << 2) + URSI_ROUND_ADD);
  endfunction

  // Remainder candidate lies in [0, 2*COLS): one conditional subtract.
  function automatic logic [CW-1:0] fold(input logic [31:0] d);
    logic [31:0] t;
    t = d;
    if (t >= COLS32) begin
      t = t - COLS32;
    end
    return t[CW-1:0];
  endfunction

  assign done_o = (phase_q == HS_MOD) && (cnt_q == 3'(MOD_LAST));

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      HS_IDLE: if (start_i) phase_d = HS_MIX1;
      HS_MIX1: phase_d = HS_MIX2;
      HS_MIX2: phase_d = HS_RND0;
      HS_RND0: phase_d = HS_RND1;
      HS_RND1: phase_d = HS_RND2;
      HS_RND2: phase_d = HS_FIN1;
      HS_FIN1: phase_d = HS_FIN2;
      HS_FIN2: phase_d = HS_FIN3;
      HS_FIN3: phase_d = HS_MOD;
      HS_MOD:  if (done_o) phase_d = HS_IDLE;
      default: phase_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= HS_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      if (phase_q == HS_MOD) begin
        cnt_q <= cnt_q + 3'd1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Key blocks are seed independent: mix them once, then run each row lane.
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      HS_IDLE: begin
        if (start_i) begin
          kb_q[0] <= key_low_i[31:0];
          kb_q[1] <= key_low_i[63:32];
          kb_q[2] <= key_high_i[31:0];
          kb_q[3] <= {24'd0, key_high_i[39:32]};
        end
      end
      HS_MIX1: begin
        for (int i = 0; i < 4; i++) kb_q[i] <= 32'(kb_q[i] * URSI_C1);
      end
      HS_MIX2: begin
        for (int i = 0; i < 4; i++) kb_q[i] <= 32'(rotl(kb_q[i], 15) * URSI_C2);
      end
      HS_RND0: begin
        for (int r = 0; r < ROWS; r++) h_q[r] <= hround(ursi_seed(r), kb_q[0]);
      end
      HS_RND1: begin
        for (int r = 0; r < ROWS; r++) h_q[r] <= hround(h_q[r], kb_q[1]);
      end
      HS_RND2: begin
        for (int r = 0; r < ROWS; r++) h_q[r] <= hround(h_q[r], kb_q[2]);
      end
      HS_FIN1: begin
        for (int r = 0; r < ROWS; r++) begin
          h_q[r] <= 32'(((h_q[r] ^ kb_q[3] ^ URSI_KEY_BYTES) ^
                        ((h_q[r] ^ kb_q[3] ^ URSI_KEY_BYTES) >> 16)) * URSI_C3);
        end
      end
      HS_FIN2: begin
        for (int r = 0; r < ROWS; r++) h_q[r] <= 32'((h_q[r] ^ (h_q[r] >> 13)) * URSI_C4);
      end
      HS_FIN3: begin
        for (int r = 0; r < ROWS; r++) begin
          h_q[r] <= h_q[r] ^ (h_q[r] >> 16);
        end
      end
      HS_MOD: begin
        // Hold the hash; estimate the quotient, scale it back, then fold.
        for (int r = 0; r < ROWS; r++) begin
          if (cnt_q == 3'd0) begin
            prod_q[r] <= 65'(h_q[r]) * 65'(RECIP);
          end else if (cnt_q == 3'd1) begin
            qd_q[r] <= 32'(32'(prod_q[r] >> (32 + CW)) * COLS32);
          end else begin
            rem_q[r] <= fold(32'(h_q[r] - qd_q[r]));
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign col_o = rem_q;

endmodule
